[rtl/wcf_pkg.sv]
package wcf_pkg;

  localparam int unsigned MtN = 624;

  localparam logic [31:0] MT_MULT    = 32'd1812433253;
  localparam logic [31:0] MT_MAG     = 32'h9908b0df;
  localparam logic [31:0] THR_RESET  = 32'd2513487876;
  localparam logic [31:0] SEED_RESET = 32'd12345;

  localparam logic [9:0] MT_LAST  = 10'd623;
  localparam logic [9:0] MT_FULL  = 10'd624;
  localparam logic [9:0] MT_SHIFT = 10'd397;
  localparam logic [9:0] MT_WRAP  = 10'd227;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_SEED      = 2'd1;

  typedef struct packed {
    logic seed;   // restart generator from seed register
    logic next;   // draw one word
  } rng_ctl_t;

  typedef struct packed {
    logic        ready;
    logic        valid;
    logic [31:0] word;
  } rng_st_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/wcf_rng.sv]
module wcf_rng (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        seed_i,
  input  wcf_pkg::rng_ctl_t  ctl_i,
  output wcf_pkg::rng_st_t   st_o
);

  typedef enum logic [3:0] {
    R_INIT, R_SMUL, R_SADD, R_IDLE,
    R_TW0, R_TWCUR, R_TWNX, R_TWMM, R_TWWR,
    R_GRD, R_GOUT
  } state_e;

  state_e      state_q;
  logic [9:0]  idx_q;
  logic [31:0] p_q, prod_q, cur_q, nxt_q, word_q;
  logic        valid_q;

  logic [31:0] mem_q [wcf_pkg::MtN];
  logic [31:0] rdata_q;

  logic [9:0]  raddr, waddr;
  logic        we;
  logic [31:0] wdata, y_tw;

  assign y_tw = {cur_q[31], nxt_q[30:0]};

  always_comb begin
    raddr = idx_q;
    waddr = idx_q;
    we    = 1'b0;
    wdata = prod_q + {22'd0, idx_q};
    unique case (state_q)
      R_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = seed_i;
      end
      R_SADD: we = 1'b1;
      R_TW0:  raddr = '0;
      R_TWNX: raddr = (idx_q == wcf_pkg::MT_LAST) ? 10'd0 : idx_q + 10'd1;
      R_TWMM: raddr = (idx_q < wcf_pkg::MT_WRAP) ? idx_q + wcf_pkg::MT_SHIFT
                                                  : idx_q - wcf_pkg::MT_WRAP;
      R_TWWR: begin
        we    = 1'b1;
        wdata = rdata_q ^ {1'b0, y_tw[31:1]} ^ (y_tw[0] ? wcf_pkg::MT_MAG : 32'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_INIT;
      idx_q   <= '0;
      valid_q <= 1'b0;
      p_q     <= '0;
      prod_q  <= '0;
      cur_q   <= '0;
      nxt_q   <= '0;
      word_q  <= '0;
    end else begin
      valid_q <= 1'b0;
      if (ctl_i.seed) begin
        state_q <= R_INIT;
      end else begin
        unique case (state_q)
          R_INIT: begin
            p_q     <= seed_i;
            idx_q   <= '0;
            state_q <= R_SMUL;
          end
          R_SMUL: begin
            prod_q  <= wcf_pkg::MT_MULT * (p_q ^ (p_q >> 30));
            idx_q   <= idx_q + 10'd1;
            state_q <= R_SADD;
          end
          R_SADD: begin
            p_q <= wdata;
            if (idx_q == wcf_pkg::MT_LAST) begin
              idx_q   <= wcf_pkg::MT_FULL;
              state_q <= R_IDLE;
            end else begin
              state_q <= R_SMUL;
            end
          end
          R_IDLE: begin
            if (ctl_i.next) begin
              state_q <= (idx_q == wcf_pkg::MT_FULL) ? R_TW0 : R_GRD;
            end
          end
          R_TW0: begin
            idx_q   <= '0;
            state_q <= R_TWCUR;
          end
          R_TWCUR: begin
            cur_q   <= rdata_q;
            state_q <= R_TWNX;
          end
          R_TWNX: state_q <= R_TWMM;
          R_TWMM: begin
            nxt_q   <= rdata_q;
            state_q <= R_TWWR;
          end
          R_TWWR: begin
            cur_q <= nxt_q;
            if (idx_q == wcf_pkg::MT_LAST) begin
              idx_q   <= '0;
              state_q <= R_GRD;
            end else begin
              idx_q   <= idx_q + 10'd1;
              state_q <= R_TWNX;
            end
          end
          R_GRD: state_q <= R_GOUT;
          R_GOUT: begin
            word_q  <= wcf_pkg::temper(rdata_q);
            valid_q <= 1'b1;
            idx_q   <= idx_q + 10'd1;
            state_q <= R_IDLE;
          end
          default: state_q <= R_IDLE;
        endcase
      end
    end
  end

  assign st_o.ready = (state_q == R_IDLE);
  assign st_o.valid = valid_q;
  assign st_o.word  = word_q;

endmodule

[rtl/wolff_cluster_flip.sv]
// Channel | Dir | Signals                         | Content
// s_axis  | in  | tvalid/tready/tdata[15:0]       | start_site
// m_axis  | out | tvalid/tready/tdata[31:0]       | flip_count, magnet_sum
// cfg     | in  | cfg_valid/ready/index[1:0]/data | 0 accept_threshold, 1 rng_seed
//
// A seed runs through setup and wrap-up steps (accept, two-pass site split on the
// shared reciprocal multiplier, seed read and flip, last queue check, result), plus
// work per queued site, per neighbor test and per random draw; every 624 draws the
// generator regenerates its table. Spin store port and the single random-word unit
// set the pace. After reset a clearing pass writes the spin store while s_axis_tready
// stays low; generator seeding runs alongside. A result waiting on m_axis does not
// block the next transaction on s_axis; that step then stalls at its end until the
// result slot frees up.
module wolff_cluster_flip #(
  parameter int unsigned LATTICE_SIDE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] start_site
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [12:0] flip_count, [26:13] magnet_sum
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned RW     = $clog2(LATTICE_SIDE);
  localparam int unsigned SITES  = LATTICE_SIDE * LATTICE_SIDE;
  localparam int unsigned QAW    = $clog2(SITES);
  localparam int unsigned CW     = $clog2(SITES + 1);
  localparam int unsigned SDEPTH = 1 << (2 * RW);
  localparam int unsigned DivS   = 12 + RW;
  localparam int unsigned DivM   = ((1 << DivS) + LATTICE_SIDE - 1) / LATTICE_SIDE;

  localparam logic [RW-1:0] RowMax = RW'(LATTICE_SIDE - 1);
  localparam logic [11:0]   SideV  = 12'(LATTICE_SIDE);
  localparam logic [13:0]   DivMul = 14'(DivM);

  typedef enum logic [3:0] {
    C_CLEAR, C_IDLE, C_DIV, C_ROW, C_SEED_RD, C_SEED_WR, C_POP, C_CUR,
    C_NB, C_TEST, C_REQ, C_WAIT, C_DONE
  } state_e;

  state_e             state_q;
  logic [RW-1:0]      row_q, col_q;
  logic [11:0]        val_q;
  logic [2*RW-1:0]    cur_q, nb_q, nb;
  logic [1:0]         k_q;
  logic [CW-1:0]      head_q, tail_q;
  logic               old_q;
  logic [13:0]        magnet_q;
  logic [31:0]        thr_q, seed_q;
  logic               seed_go_q;
  logic               m_valid_q;
  logic [26:0]        m_data_q;

  logic               spin_mem [SDEPTH];
  logic               spin_rd_q;
  logic [2*RW-1:0]    queue_mem [SITES];
  logic [2*RW-1:0]    q_rd_q;

  logic               spin_we, spin_wdata;
  logic [2*RW-1:0]    spin_waddr, spin_raddr;
  logic               q_we;
  logic [QAW-1:0]     q_waddr, q_raddr;
  logic [2*RW-1:0]    q_wdata;

  logic [25:0]        div_prod;
  logic [11:0]        div_quo, div_rem;
  logic [23:0]        div_back;

  wcf_pkg::rng_ctl_t  rng_ctl;
  wcf_pkg::rng_st_t   rng_st;
  logic               flip;

  logic [RW-1:0] cur_row, cur_col, row_up, row_dn, col_up, col_dn;

  assign cur_row = cur_q[2*RW-1:RW];
  assign cur_col = cur_q[RW-1:0];
  assign row_up  = (cur_row == RowMax) ? '0 : cur_row + 1'b1;
  assign row_dn  = (cur_row == '0) ? RowMax : cur_row - 1'b1;
  assign col_up  = (cur_col == RowMax) ? '0 : cur_col + 1'b1;
  assign col_dn  = (cur_col == '0) ? RowMax : cur_col - 1'b1;

  // reciprocal multiply by the side, exact for any 12-bit operand;
  // used once for the column and once more on the quotient for the row
  assign div_prod = val_q * DivMul;
  assign div_quo  = 12'(div_prod >> DivS);
  assign div_back = div_quo * SideV;
  assign div_rem  = val_q - div_back[11:0];

  always_comb begin
    case (k_q)
      2'd0:    nb = {row_up, cur_col};
      2'd1:    nb = {row_dn, cur_col};
      2'd2:    nb = {cur_row, col_up};
      default: nb = {cur_row, col_dn};
    endcase
  end

  assign flip = rng_st.valid && (rng_st.word < thr_q);

  assign rng_ctl.seed = seed_go_q;
  assign rng_ctl.next = (state_q == C_REQ) && rng_st.ready;

  wcf_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seed_i (seed_q),
    .ctl_i  (rng_ctl),
    .st_o   (rng_st)
  );

  always_comb begin
    spin_we    = 1'b0;
    spin_waddr = {row_q, col_q};
    spin_wdata = 1'b1;
    spin_raddr = {row_q, col_q};
    q_we       = 1'b0;
    q_waddr    = tail_q[QAW-1:0];
    q_wdata    = {row_q, col_q};
    q_raddr    = head_q[QAW-1:0];
    unique case (state_q)
      C_CLEAR: spin_we = 1'b1;
      C_SEED_WR: begin
        spin_we    = 1'b1;
        spin_wdata = ~spin_rd_q;
        q_we       = 1'b1;
      end
      C_NB: spin_raddr = nb;
      C_WAIT: begin
        if (flip) begin
          spin_we    = 1'b1;
          spin_waddr = nb_q;
          spin_wdata = ~old_q;
          q_we       = 1'b1;
          q_wdata    = nb_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (spin_we) begin
      spin_mem[spin_waddr] <= spin_wdata;
    end
    spin_rd_q <= spin_mem[spin_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rd_q <= queue_mem[q_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_CLEAR;
      row_q     <= '0;
      col_q     <= '0;
      val_q     <= '0;
      cur_q     <= '0;
      nb_q      <= '0;
      k_q       <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      old_q     <= 1'b1;
      magnet_q  <= 14'(SITES);
      thr_q     <= wcf_pkg::THR_RESET;
      seed_q    <= wcf_pkg::SEED_RESET;
      seed_go_q <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      seed_go_q <= cfg_valid_i && (cfg_index_i == wcf_pkg::CFG_SEED);
      if (cfg_valid_i) begin
        if (cfg_index_i == wcf_pkg::CFG_THRESHOLD) begin
          thr_q <= cfg_data_i;
        end else if (cfg_index_i == wcf_pkg::CFG_SEED) begin
          seed_q <= cfg_data_i;
        end
      end

      if (m_valid_q && m_axis_tready && (state_q != C_DONE)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        C_CLEAR: begin
          if (col_q == RowMax) begin
            col_q <= '0;
            if (row_q == RowMax) begin
              row_q   <= '0;
              state_q <= C_IDLE;
            end else begin
              row_q <= row_q + 1'b1;
            end
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        C_IDLE: begin
          if (s_axis_tvalid) begin
            val_q   <= s_axis_tdata[11:0];
            row_q   <= '0;
            head_q  <= '0;
            tail_q  <= '0;
            state_q <= C_DIV;
          end
        end
        C_DIV: begin
          col_q   <= div_rem[RW-1:0];
          val_q   <= div_quo;
          state_q <= C_ROW;
        end
        C_ROW: begin
          // quotient modulo the side folds in the wrap of the site index
          row_q   <= div_rem[RW-1:0];
          state_q <= C_SEED_RD;
        end
        C_SEED_RD: state_q <= C_SEED_WR;
        C_SEED_WR: begin
          old_q    <= spin_rd_q;
          magnet_q <= spin_rd_q ? magnet_q - 14'd2 : magnet_q + 14'd2;
          tail_q   <= CW'(1);
          state_q  <= C_POP;
        end
        C_POP: begin
          if (head_q == tail_q) begin
            state_q <= C_DONE;
          end else begin
            head_q  <= head_q + 1'b1;
            state_q <= C_CUR;
          end
        end
        C_CUR: begin
          cur_q   <= q_rd_q;
          k_q     <= '0;
          state_q <= C_NB;
        end
        C_NB: begin
          nb_q    <= nb;
          state_q <= C_TEST;
        end
        C_TEST: begin
          if (spin_rd_q == old_q) begin
            state_q <= C_REQ;
          end else if (k_q == 2'd3) begin
            state_q <= C_POP;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= C_NB;
          end
        end
        C_REQ: begin
          if (rng_st.ready) begin
            state_q <= C_WAIT;
          end
        end
        C_WAIT: begin
          if (rng_st.valid) begin
            if (flip) begin
              tail_q   <= tail_q + 1'b1;
              magnet_q <= old_q ? magnet_q - 14'd2 : magnet_q + 14'd2;
            end
            if (k_q == 2'd3) begin
              state_q <= C_POP;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= C_NB;
            end
          end
        end
        C_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {magnet_q, 13'(tail_q)};
            state_q   <= C_IDLE;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == C_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_data_q};
  assign cfg_ready_o   = 1'b1;

endmodule

[rtl/wcf_checker.sv]
module wcf_checker #(
  parameter int unsigned LATTICE_SIDE = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  localparam logic SitesOdd = 1'(LATTICE_SIDE * LATTICE_SIDE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // every flip changes the sum by two, so parity follows the site count
  a_magnet_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13] == SitesOdd))
    else $error("magnetization parity wrong");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again during cluster growth");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a cluster in progress");

endmodule

bind wolff_cluster_flip wcf_checker #(.LATTICE_SIDE(LATTICE_SIDE)) u_wcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
